>>> rtl/core/hbsf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbsf_pkg
// Shared types and constants of the histogram best-split finder.
// ----------------------------------------------------------------------------
package hbsf_pkg;

    localparam int DEFAULT_MAX_BINS = 256;
    localparam int QUEUE_DEPTH      = 2;
    localparam int CFG_IDX_W        = 2;
    localparam int CFG_DATA_W       = 40;
    localparam int NUM_W            = 82;  // numerator and quotient width
    localparam int DIV_W            = 42;  // divisor width

    localparam logic [CFG_IDX_W-1:0] CFG_QUAD_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LAMBDA     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_WEIGHT = 2'd2;

    localparam logic [39:0]        MIN_WEIGHT_RESET = 40'd65536;
    localparam logic signed [47:0] SCORE_MINUS_ONE  = -48'sd65536;
    localparam logic [47:0]        SCORE_MAX        = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0]        SCORE_MIN        = 48'h8000_0000_0000;

    typedef struct packed {
        logic signed [31:0] bin_gradient;
        logic [31:0]        bin_weight;
        logic signed [39:0] node_gradient_total;
        logic [39:0]        node_weight_total;
        logic               last_bin;
    } t_in_item;

    typedef struct packed {
        logic signed [47:0] best_score;
        logic [7:0]         best_boundary;
        logic               split_found;
    } t_out_item;

    typedef struct packed {
        logic               last;
        logic [7:0]         boundary;
        logic signed [40:0] gl;
        logic [39:0]        wl;
        logic signed [40:0] gr;
        logic [39:0]        wr;
        logic signed [40:0] gt;
        logic [39:0]        wt;
    } t_job;

endpackage

>>> rtl/core/histogram_best_split_finder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// histogram_best_split_finder_unit
// Finds the best split boundary of one feature histogram at one tree node.
// ----------------------------------------------------------------------------
// Bins enter on the input channel (valid/ready), one item per bin, each with
// the node's total gradient and weight. The front keeps the left-side sums and
// takes a bin every cycle while the job queue has room. Boundaries that pass
// the side-weight check, and the last bin, go into a two-entry queue.
// The back scores one boundary at a time with a shared 21x21 multiplier and a
// one-bit-per-cycle restoring divider over 82 bits. A scored boundary takes
// two quotients in mean mode and three squares and quotients in quadratic
// mode; bins that fail the weight check cost the back nothing. The result
// item is written to the output register from the emit state, which the
// back enters when the last bin reaches the head of the queue.
// The result sits in an output register until it is taken; while it waits,
// the back keeps working and bins keep entering until the queue fills.
// Reset is synchronous and active low: it clears the left sums, the best score
// (to -1.0), the queue and the registers to their reset values. Configuration
// writes are taken at once and must only happen while the block is idle.
// ----------------------------------------------------------------------------
module histogram_best_split_finder_unit #(
    parameter int MAX_BINS = hbsf_pkg::DEFAULT_MAX_BINS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  hbsf_pkg::t_in_item                  i_in_item,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output hbsf_pkg::t_out_item                 o_out_item,
    input  logic                               i_cfg_we,
    input  logic [hbsf_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [hbsf_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import hbsf_pkg::*;

    // Configuration registers.
    logic        r_quad;
    logic [31:0] r_lambda;
    logic [39:0] r_min_weight;

    logic push, push_ready, job_valid, pop;
    t_job push_job, head_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quad       <= 1'b0;
            r_lambda     <= '0;
            r_min_weight <= MIN_WEIGHT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_QUAD_MODE:  r_quad       <= i_cfg_data[0];
                CFG_LAMBDA:     r_lambda     <= i_cfg_data[31:0];
                CFG_MIN_WEIGHT: r_min_weight <= i_cfg_data[39:0];
                default: ;
            endcase
        end
    end

    // Front: running sums, bin count and the side-weight check.
    hbsf_front #(
        .MAX_BINS(MAX_BINS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_item    (i_in_item),
        .i_min_weight (r_min_weight),
        .o_push       (push),
        .o_job        (push_job),
        .i_push_ready (push_ready)
    );

    // Job queue that decouples bin intake from scoring.
    hbsf_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_job        (push_job),
        .o_push_ready (push_ready),
        .i_pop        (pop),
        .o_valid      (job_valid),
        .o_job        (head_job)
    );

    // Back: scoring, best tracking and the result register.
    hbsf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_quad      (r_quad),
        .i_lambda    (r_lambda),
        .i_job_valid (job_valid),
        .i_job       (head_job),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

>>> rtl/core/hbsf_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbsf_queue
// Small register FIFO of jobs between the front and the back.
// ----------------------------------------------------------------------------
module hbsf_queue #(
    parameter int DEPTH = hbsf_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  hbsf_pkg::t_job i_job,
    output logic          o_push_ready,
    input  logic          i_pop,
    output logic          o_valid,
    output hbsf_pkg::t_job o_job
);
    import hbsf_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;
    logic          do_push, do_pop;

    assign o_push_ready = (r_cnt != CW'(DEPTH));
    assign o_valid      = (r_cnt != '0);
    assign o_job        = r_mem[r_rp];
    assign do_push      = i_push && o_push_ready;
    assign do_pop       = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

>>> rtl/core/hbsf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbsf_front
// Accepts bins, keeps the left-side sums and checks the side weights.
// ----------------------------------------------------------------------------
module hbsf_front #(
    parameter int MAX_BINS = hbsf_pkg::DEFAULT_MAX_BINS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  hbsf_pkg::t_in_item i_in_item,
    input  logic [39:0]       i_min_weight,
    output logic              o_push,
    output hbsf_pkg::t_job     o_job,
    input  logic              i_push_ready
);
    import hbsf_pkg::*;

    localparam int CW = $clog2(MAX_BINS);

    logic [39:0]   r_wl, r_gl, n_wl, n_gl;
    logic [CW-1:0] r_cnt, cnt_inc;
    logic [40:0]   wr;
    logic          accept, capped, qualified;

    assign o_in_ready = i_push_ready;
    assign accept     = i_in_valid && i_push_ready;
    assign capped     = (r_cnt >= CW'(MAX_BINS - 1));
    assign cnt_inc    = r_cnt + 1'b1;

    assign n_wl = r_wl + {8'd0, i_in_item.bin_weight};
    assign n_gl = r_gl + {{8{i_in_item.bin_gradient[31]}}, i_in_item.bin_gradient};
    assign wr   = {1'b0, i_in_item.node_weight_total} - {1'b0, n_wl};

    // Both sides must reach the minimum; a negative right side fails.
    assign qualified = (n_wl >= i_min_weight) && !wr[40] && (wr[39:0] >= i_min_weight);

    assign o_push = accept && (i_in_item.last_bin || (!capped && qualified));

    always_comb begin
        o_job          = '0;
        o_job.last     = i_in_item.last_bin;
        o_job.boundary = 8'(cnt_inc);
        o_job.gl       = {n_gl[39], n_gl};
        o_job.wl       = n_wl;
        o_job.gt       = {i_in_item.node_gradient_total[39], i_in_item.node_gradient_total};
        o_job.gr       = o_job.gt - o_job.gl;
        o_job.wr       = wr[39:0];
        o_job.wt       = i_in_item.node_weight_total;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wl  <= '0;
            r_gl  <= '0;
            r_cnt <= '0;
        end else if (accept) begin
            if (i_in_item.last_bin) begin
                r_wl  <= '0;
                r_gl  <= '0;
                r_cnt <= '0;
            end else if (!capped) begin
                r_wl  <= n_wl;
                r_gl  <= n_gl;
                r_cnt <= cnt_inc;
            end
        end
    end

endmodule

>>> rtl/core/hbsf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbsf_back
// Scores one boundary at a time with a shared multiplier and divider.
// ----------------------------------------------------------------------------
module hbsf_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_quad,
    input  logic [31:0]        i_lambda,
    input  logic               i_job_valid,
    input  hbsf_pkg::t_job      i_job,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output hbsf_pkg::t_out_item o_out_item
);
    import hbsf_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_LOAD, S_MUL, S_DIV, S_SUM, S_FINAL, S_BEST, S_EMIT
    } t_state;

    t_state             r_state;
    t_job               r_job;
    logic [1:0]         r_term, r_mstep;
    logic [40:0]        r_m;
    logic               r_neg, r_neg0, r_neg1;
    logic [NUM_W-1:0]   r_acc, r_quo, r_q0, r_q1, r_q2;
    logic [DIV_W-1:0]   r_d;
    logic [DIV_W-1:0]   r_rem;
    logic [6:0]         r_bit;
    logic [NUM_W:0]     r_sum;
    logic signed [47:0] r_score, r_best;
    logic [7:0]         r_bound;
    logic               r_found;
    logic               r_out_valid;
    t_out_item          r_out;

    logic signed [40:0] sel_g;
    logic [DIV_W-1:0]   sel_d;
    logic [40:0]        sel_m;
    logic [20:0]        mx, my;
    logic [41:0]        prod;
    logic [NUM_W-1:0]   prod_sh, quo_fix;
    logic [DIV_W:0]     rem_sh;
    logic               take;
    logic [NUM_W:0]     v0, v1, qd, dpos, dneg, aval;
    logic [47:0]        fscore;
    logic [1:0]         last_term;
    logic               emit_now;

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
    assign last_term   = i_quad ? 2'd2 : 2'd1;

    // The result register can take a new item when empty or being drained.
    assign emit_now = (r_state == S_EMIT) && (!r_out_valid || i_out_ready);

    always_comb begin
        case (r_term)
            2'd0: begin
                sel_g = r_job.gl;
                sel_d = {2'b0, r_job.wl} + (i_quad ? {10'd0, i_lambda} : '0);
            end
            2'd1: begin
                sel_g = r_job.gr;
                sel_d = {2'b0, r_job.wr} + (i_quad ? {10'd0, i_lambda} : '0);
            end
            default: begin
                sel_g = r_job.gt;
                sel_d = {2'b0, r_job.wt};
            end
        endcase
        sel_m = sel_g[40] ? 41'(-sel_g) : 41'(sel_g);
    end

    // Square of a 41-bit magnitude from three 21-bit partial products.
    always_comb begin
        case (r_mstep)
            2'd0: begin
                mx = r_m[20:0];
                my = r_m[20:0];
            end
            2'd1: begin
                mx = r_m[20:0];
                my = {1'b0, r_m[40:21]};
            end
            default: begin
                mx = {1'b0, r_m[40:21]};
                my = {1'b0, r_m[40:21]};
            end
        endcase
        prod = mx * my;
        case (r_mstep)
            2'd0:    prod_sh = NUM_W'(prod);
            2'd1:    prod_sh = NUM_W'(prod) << 22;
            default: prod_sh = NUM_W'(prod) << 42;
        endcase
    end

    assign rem_sh  = {r_rem, r_acc[NUM_W-1]};
    assign take    = (rem_sh >= {1'b0, r_d});
    assign quo_fix = (r_d == '0) ? '0 : {r_quo[NUM_W-2:0], take};

    always_comb begin
        v0   = r_neg0 ? ('0 - {1'b0, r_q0}) : {1'b0, r_q0};
        v1   = r_neg1 ? ('0 - {1'b0, r_q1}) : {1'b0, r_q1};
        qd   = {1'b0, r_q2};
        dpos = r_sum - qd;
        dneg = qd - r_sum;
        aval = r_sum[NUM_W] ? ('0 - r_sum) : r_sum;
        if (i_quad) begin
            if (r_sum >= qd) begin
                fscore = (dpos > {35'd0, SCORE_MAX}) ? SCORE_MAX : dpos[47:0];
            end else begin
                fscore = (dneg > {35'd0, SCORE_MIN}) ? SCORE_MIN : 48'(-dneg[47:0]);
            end
        end else begin
            fscore = (aval > {35'd0, SCORE_MAX}) ? SCORE_MAX : aval[47:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_best      <= SCORE_MINUS_ONE;
            r_bound     <= '0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
            o_pop       <= 1'b0;
        end else begin
            o_pop <= emit_now
                  || (r_state == S_IDLE && i_job_valid && !o_pop && !i_job.last);
            if (emit_now) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_job_valid && !o_pop) begin
                        r_job  <= i_job;
                        r_term <= 2'd0;
                        r_state <= i_job.last ? S_EMIT : S_LOAD;
                    end
                end
                S_LOAD: begin
                    r_m     <= sel_m;
                    r_neg   <= sel_g[40];
                    r_d     <= sel_d;
                    r_rem   <= '0;
                    r_bit   <= 7'(NUM_W - 1);
                    r_mstep <= 2'd0;
                    if (i_quad) begin
                        r_acc   <= '0;
                        r_state <= S_MUL;
                    end else begin
                        r_acc   <= NUM_W'(sel_m) << 16;
                        r_state <= S_DIV;
                    end
                end
                S_MUL: begin
                    r_acc   <= r_acc + prod_sh;
                    r_mstep <= r_mstep + 1'b1;
                    if (r_mstep == 2'd2) begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_acc <= {r_acc[NUM_W-2:0], 1'b0};
                    r_rem <= take ? DIV_W'(rem_sh - {1'b0, r_d}) : rem_sh[DIV_W-1:0];
                    r_quo <= {r_quo[NUM_W-2:0], take};
                    r_bit <= r_bit - 1'b1;
                    if (r_bit == '0) begin
                        case (r_term)
                            2'd0: begin
                                r_q0   <= quo_fix;
                                r_neg0 <= r_neg;
                            end
                            2'd1: begin
                                r_q1   <= quo_fix;
                                r_neg1 <= r_neg;
                            end
                            default: r_q2 <= quo_fix;
                        endcase
                        if (r_term == last_term) begin
                            r_state <= S_SUM;
                        end else begin
                            r_term  <= r_term + 1'b1;
                            r_state <= S_LOAD;
                        end
                    end
                end
                S_SUM: begin
                    r_sum   <= i_quad ? ({1'b0, r_q0} + {1'b0, r_q1}) : (v0 - v1);
                    r_state <= S_FINAL;
                end
                S_FINAL: begin
                    r_score <= fscore;
                    r_state <= S_BEST;
                end
                S_BEST: begin
                    r_found <= 1'b1;
                    if (r_score > r_best) begin
                        r_best  <= r_score;
                        r_bound <= r_job.boundary;
                    end
                    r_state <= S_IDLE;
                end
                S_EMIT: begin
                    if (emit_now) begin
                        r_out.best_score    <= r_best;
                        r_out.best_boundary <= r_bound;
                        r_out.split_found   <= r_found;
                        r_best              <= SCORE_MINUS_ONE;
                        r_bound             <= '0;
                        r_found             <= 1'b0;
                        r_state             <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

>>> dv/hbsf_split_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbsf_split_checker
// Watches the bin and result channels of the best-split finder, keeps its own
// copy of the running sums and best split, and compares every result item.
// ----------------------------------------------------------------------------
module hbsf_split_checker #(
    parameter int MAX_BINS = hbsf_pkg::DEFAULT_MAX_BINS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  hbsf_pkg::t_in_item              i_in_item,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  hbsf_pkg::t_out_item             i_out_item,
    input  logic                            i_cfg_we,
    input  logic [hbsf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [hbsf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                              o_pending,
    output int                              o_fail_count
);
    import hbsf_pkg::*;

    localparam longint SAT_HI = 64'sd140737488355327;
    localparam longint SAT_LO = -64'sd140737488355328;

    // Configuration copy.
    logic        quad_mode;
    logic [31:0] lambda_q;
    logic [39:0] min_weight;

    // Search state.
    logic [39:0] left_w;
    logic [39:0] left_g;
    longint      best_score;
    logic [7:0]  best_bnd;
    int          bins_summed;
    logic        any_found;

    t_out_item   expected_best[$];
    int          fails;

    assign o_fail_count = fails;

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        fails++;
    endtask

    function automatic longint side_mean(input longint g, input longint unsigned d);
        longint unsigned q;
        if (d == 0) begin
            return 0;
        end
        q = ((g < 0 ? -g : g) << 16) / d;
        return g < 0 ? -longint'(q) : longint'(q);
    endfunction

    function automatic logic [127:0] gain_term(input longint g, input logic [127:0] dv);
        logic [127:0] m;
        m = {64'b0, (g < 0 ? -g : g)};
        if (dv == 0) begin
            return '0;
        end
        return (m * m) / dv;
    endfunction

    function automatic longint score_boundary(input longint gl, input logic [39:0] wl,
                                              input longint gr, input longint wr,
                                              input longint gt, input logic [39:0] wt);
        longint       diff;
        logic [127:0] tl, tr, tt, s, d;
        if (!quad_mode) begin
            diff = side_mean(gl, {24'b0, wl}) - side_mean(gr, wr);
            if (diff < 0) begin
                diff = -diff;
            end
            return diff > SAT_HI ? SAT_HI : diff;
        end
        tl = gain_term(gl, {88'b0, wl} + {96'b0, lambda_q});
        tr = gain_term(gr, 128'(wr) + {96'b0, lambda_q});
        tt = gain_term(gt, {88'b0, wt});
        s  = tl + tr;
        if (s >= tt) begin
            d = s - tt;
            return d > 128'(SAT_HI) ? SAT_HI : longint'(d[63:0]);
        end
        d = tt - s;
        return d > (128'd1 << 47) ? SAT_LO : -longint'(d[63:0]);
    endfunction

    task automatic clear_search();
        left_w      = '0;
        left_g      = '0;
        best_score  = -64'sd65536;
        best_bnd    = '0;
        bins_summed = 0;
        any_found   = 1'b0;
    endtask

    task automatic take_bin(input t_in_item it);
        t_out_item res;
        longint    gl, gr, gt, wr, sc;
        if (it.last_bin) begin
            res.best_score    = best_score[47:0];
            res.best_boundary = best_bnd;
            res.split_found   = any_found;
            expected_best = {expected_best, res};
            clear_search();
            return;
        end
        // Past the last possible boundary, further bins are dropped unseen.
        if (bins_summed >= MAX_BINS - 1) begin
            return;
        end
        left_w = left_w + {8'b0, it.bin_weight};
        left_g = left_g + {{8{it.bin_gradient[31]}}, it.bin_gradient};
        bins_summed++;
        gl = longint'($signed(left_g));
        gt = longint'(it.node_gradient_total);
        wr = longint'({24'b0, it.node_weight_total}) - longint'({24'b0, left_w});
        gr = gt - gl;
        if (left_w < min_weight || wr < longint'({24'b0, min_weight})) begin
            return;
        end
        any_found = 1'b1;
        sc = score_boundary(gl, left_w, gr, wr, gt, it.node_weight_total);
        if (sc > best_score) begin
            best_score = sc;
            best_bnd   = bins_summed[7:0];
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item exp_item;
        if (!i_rst_n) begin
            quad_mode  = 1'b0;
            lambda_q   = '0;
            min_weight = MIN_WEIGHT_RESET;
            clear_search();
            expected_best.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_QUAD_MODE: begin
                        quad_mode = i_cfg_data[0];
                    end
                    CFG_LAMBDA: begin
                        lambda_q = i_cfg_data[31:0];
                    end
                    CFG_MIN_WEIGHT: begin
                        min_weight = i_cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                take_bin(i_in_item);
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_best.size() == 0) begin
                    report_mismatch("result item with nothing expected");
                end else begin
                    exp_item = expected_best.pop_front();
                    if (i_out_item.best_score !== exp_item.best_score) begin
                        report_mismatch($sformatf("best_score %0d, expected %0d",
                            i_out_item.best_score, exp_item.best_score));
                    end
                    if (i_out_item.best_boundary !== exp_item.best_boundary) begin
                        report_mismatch($sformatf("best_boundary %0d, expected %0d",
                            i_out_item.best_boundary, exp_item.best_boundary));
                    end
                    if (i_out_item.split_found !== exp_item.split_found) begin
                        report_mismatch($sformatf("split_found %0b, expected %0b",
                            i_out_item.split_found, exp_item.split_found));
                    end
                end
            end
        end
        o_pending = expected_best.size();
    end

endmodule

>>> dv/tb_histogram_best_split_finder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_histogram_best_split_finder_unit
// Streams feature histograms through the best-split finder under several
// register settings and changing back-pressure; a checker grades the results.
// ----------------------------------------------------------------------------
module tb_histogram_best_split_finder_unit;
    import hbsf_pkg::*;

    // Cycles without any accepted item before the run is declared hung. The
    // slowest legal gap is the long receiver hold plus two quadratic jobs.
    localparam int WATCHDOG_LIMIT = 20000;
    // Cycles to let the back drain before a register write or the verdict.
    localparam int DRAIN_CYCLES   = 700;
    localparam int HOLD_CYCLES    = 2500;
    localparam int ITEMS_PER_PHASE = 340;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    t_in_item              i_in_item = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out_item             o_out_item;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = CFG_QUAD_MODE;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    int pending;
    int fail_count;
    int bins_sent = 0;
    int results_taken = 0;
    int quiet_cycles = 0;
    int idle_regime = 0;

    histogram_best_split_finder_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    hbsf_split_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_item    (i_in_item),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_item   (o_out_item),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    initial begin
        forever begin
            #2 i_clk = ~i_clk;
        end
    end

    // The idle regime moves with the number of bins sent: the sender idles
    // lightly while the receiver stalls hard, then the reverse, then neither.
    always @(posedge i_clk) begin
        idle_regime <= (bins_sent < 600) ? 0 : (bins_sent < 1200) ? 1 : 2;
    end

    // Receiver. After a few results it holds ready low for a long stretch so
    // the result register and the job queue fill and the input stalls.
    initial begin
        bit held;
        int stall_pct;
        held = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!held && results_taken >= 6) begin
                held = 1'b1;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            stall_pct = (idle_regime == 0) ? 68 : (idle_regime == 1) ? 36 : 0;
            i_out_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Watchdog: any accepted item on either channel restarts the count.
    always @(posedge i_clk) begin
        if (o_out_valid && i_out_ready) begin
            results_taken <= results_taken + 1;
        end
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    function automatic logic [39:0] rand40();
        logic [63:0] r;
        r = {$urandom(), $urandom()};
        return r[39:0];
    endfunction

    function automatic logic [31:0] pick_gradient();
        case ($urandom_range(0, 5))
            0: return ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
            1, 2: return $urandom();
            3: return 32'd0;
            default: return $urandom_range(0, 8 << 16) - (4 << 16);
        endcase
    endfunction

    function automatic logic [31:0] pick_weight();
        case ($urandom_range(0, 6))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom();
            default: return $urandom_range(0, 3 << 16);
        endcase
    endfunction

    // Offers one bin and returns at the edge that accepts it. valid stays
    // high into the next bin unless the sender chooses to idle.
    task automatic send_bin(input t_in_item it);
        int idle_pct;
        idle_pct = (idle_regime == 0) ? 36 : (idle_regime == 1) ? 68 : 0;
        while ($urandom_range(0, 99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        bins_sent++;
    endtask

    task automatic offer(input logic [31:0] g, input logic [31:0] w,
                         input logic [39:0] gt, input logic [39:0] wt, input logic last);
        t_in_item it;
        it.bin_gradient        = g;
        it.bin_weight          = w;
        it.node_gradient_total = gt;
        it.node_weight_total   = wt;
        it.last_bin            = last;
        send_bin(it);
    endtask

    // One histogram of n bins, the last bin flagged. A tidy histogram carries
    // node totals that match its bins; otherwise the totals are random noise.
    task automatic send_histogram(input int n, input bit tidy);
        logic [31:0] g_bins[$];
        logic [31:0] w_bins[$];
        logic [39:0] g_total, w_total;
        g_total = '0;
        w_total = '0;
        for (int b = 0; b < n; b++) begin
            g_bins = {g_bins, pick_gradient()};
            w_bins = {w_bins, pick_weight()};
            g_total += {{8{g_bins[b][31]}}, g_bins[b]};
            w_total += {8'b0, w_bins[b]};
        end
        if (!tidy) begin
            g_total = rand40();
            w_total = rand40();
        end
        for (int b = 0; b < n; b++) begin
            offer(g_bins[b], w_bins[b], g_total, w_total, b == n - 1);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [39:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Waits for every expected result, then lets the back run dry.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_config(input logic mode, input logic [31:0] lambda,
                              input logic [39:0] min_w);
        drain();
        write_reg(CFG_QUAD_MODE, {39'b0, mode});
        write_reg(CFG_LAMBDA, {8'b0, lambda});
        write_reg(CFG_MIN_WEIGHT, min_w);
    endtask

    // Hand-picked histograms: a lone last bin, field extremes, a left side
    // heavier than the node, zero divisors, tied scores and the most
    // negative node gradient.
    task automatic directed_bins();
        offer(32'd0, 32'd0, 40'd0, 40'd0, 1'b1);
        offer(32'h7FFF_FFFF, 32'hFFFF_FFFF, 40'h7F_FFFF_FFFF, 40'hFF_FFFF_FFFF, 1'b0);
        offer(32'h8000_0000, 32'd0, 40'h7F_FFFF_FFFF, 40'hFF_FFFF_FFFF, 1'b0);
        offer(32'h0001_0000, 32'h0001_0000, 40'h7F_FFFF_FFFF, 40'hFF_FFFF_FFFF, 1'b1);
        offer(32'h0001_0000, 32'h0005_0000, 40'd0, 40'h1_0000, 1'b0);
        offer(32'd0, 32'h0001_0000, 40'd0, 40'h1_0000, 1'b0);
        offer(32'd0, 32'd0, 40'd0, 40'h1_0000, 1'b1);
        offer(32'h0003_0000, 32'd0, 40'h3_0000, 40'd0, 1'b0);
        offer(32'd0, 32'd0, 40'h3_0000, 40'd0, 1'b1);
        for (int b = 0; b < 5; b++) begin
            offer(32'h0001_0000, 32'h0002_0000, 40'h4_0000, 40'h8_0000, b == 4);
        end
        offer(32'hFFFE_0000, 32'h0001_0000, 40'h80_0000_0000, 40'h3_0000, 1'b0);
        offer(32'h0001_0000, 32'h0001_0000, 40'h80_0000_0000, 40'h3_0000, 1'b0);
        offer(32'd0, 32'h0001_0000, 40'h80_0000_0000, 40'h3_0000, 1'b1);
    endtask

    task automatic random_phase(input bit with_long);
        int start;
        int n;
        start = bins_sent;
        // More bins than the block can score, in one tidy histogram whose node
        // totals match its bins.
        if (with_long) begin
            send_histogram(262, 1'b1);
        end
        while (bins_sent - start < ITEMS_PER_PHASE) begin
            n = ($urandom_range(0, 39) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
            send_histogram(n, $urandom_range(0, 99) < 85);
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_config(1'b0, 32'd0, 40'h1_0000);
        directed_bins();
        set_config(1'b1, 32'd0, 40'd0);
        directed_bins();

        set_config(1'b0, $urandom(), 40'd0);
        random_phase(1'b1);
        set_config(1'b1, 32'hFFFF_FFFF, 40'($urandom_range(0, 2 << 16)));
        random_phase(1'b0);
        set_config(1'b1, $urandom(), 40'hFF_FFFF_FFFF);
        random_phase(1'b0);
        set_config(1'b0, 32'd0, 40'h1_0000 * $urandom_range(0, 3));
        random_phase(1'b0);
        set_config(1'b1, $urandom_range(0, 1 << 16), 40'h1_0000);
        random_phase(1'b0);

        drain();
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/core/hbsf_pkg.sv
rtl/core/hbsf_queue.sv
rtl/core/hbsf_front.sv
rtl/core/hbsf_back.sv
rtl/core/histogram_best_split_finder_unit.sv
dv/hbsf_split_checker.sv
dv/tb_histogram_best_split_finder_unit.sv
